// ===== sv/u7se_pkg.sv =====
// types, constants and helper functions for the utf-7 stream encoder
// used by every module of the encoder; depends on nothing else
package u7se_pkg;

   localparam int U7SE_FIFO_DEPTH = 2;
   localparam int U7SE_MAX_CHARS  = 5;

   localparam logic [6:0]  CHAR_PLUS  = 7'h2B;
   localparam logic [6:0]  CHAR_MINUS = 7'h2D;
   localparam logic [15:0] DIRECT_LO  = 16'h0020;
   localparam logic [15:0] DIRECT_HI  = 16'h007E;

   // input word
   typedef struct packed {
      logic [15:0] code_unit;
      logic        end_of_text;
   } req_type;

   // result word
   typedef struct packed {
      logic [6:0] ascii_char;
      logic       last_of_run;
   } rsp_type;

   // one item's characters, first in slot 0
   typedef struct packed {
      logic [U7SE_MAX_CHARS-1:0][6:0] chars;
      logic [2:0]                     count;
   } rec_type;

   // record queue status
   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   // base64 alphabet
   function automatic logic [6:0] b64_char(input logic [5:0] v);
      logic [6:0] c;
      if (v < 6'd26) begin
         c = 7'h41 + {1'b0, v};
      end else if (v < 6'd52) begin
         c = 7'h61 + {1'b0, v} - 7'd26;
      end else if (v < 6'd62) begin
         c = 7'h30 + {1'b0, v} - 7'd52;
      end else if (v == 6'd62) begin
         c = 7'h2B;
      end else begin
         c = 7'h2F;
      end
      return c;
   endfunction

   // leftover stream bits padded with zeros on the right
   function automatic logic [6:0] flush_char(input logic [3:0] bits, input logic [2:0] cnt);
      logic [6:0] c;
      if (cnt == 3'd2) begin
         c = b64_char({bits[1:0], 4'b0000});
      end else begin
         c = b64_char({bits, 2'b00});
      end
      return c;
   endfunction

endpackage

// ===== sv/u7se_front.sv =====
// front end: classifies each code unit, keeps the base64 run state and
// builds the item's character record; depends on u7se_pkg
module u7se_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  u7se_pkg::req_type req_word,
   output u7se_pkg::rec_type rec
);
   import u7se_pkg::*;

   logic       run_ff, run_in;
   logic [3:0] pbits_ff, pbits_in;
   logic [2:0] pcnt_ff, pcnt_in;

   logic       direct;
   logic [2:0] n;
   logic [3:0] pb;
   logic [2:0] pc;
   logic [19:0] acc;
   logic [3:0] rem;
   logic [2:0] rc;

   // build the characters and the next run state
   always_comb begin
      rec      = '0;
      n        = '0;
      run_in   = 1'b0;
      pbits_in = '0;
      pcnt_in  = '0;
      pb       = run_ff ? pbits_ff : 4'd0;
      pc       = run_ff ? pcnt_ff : 3'd0;
      acc      = {pb, req_word.code_unit};
      rem      = '0;
      rc       = '0;
      direct   = (req_word.code_unit >= DIRECT_LO) && (req_word.code_unit <= DIRECT_HI)
                 && (req_word.code_unit != {9'd0, CHAR_PLUS});
      if (direct) begin
         // close an open run, then the unit itself
         if (run_ff) begin
            if (pcnt_ff != 3'd0) begin
               rec.chars[n] = flush_char(pbits_ff, pcnt_ff);
               n = n + 3'd1;
            end
            rec.chars[n] = CHAR_MINUS;
            n = n + 3'd1;
         end
         rec.chars[n] = req_word.code_unit[6:0];
         n = n + 3'd1;
      end else begin
         if (!run_ff) begin
            rec.chars[n] = CHAR_PLUS;
            n = n + 3'd1;
         end
         // six-bit groups of the continuous stream
         unique case (pc)
            3'd2: begin
               rec.chars[n] = b64_char(acc[17:12]);
               rec.chars[n + 3'd1] = b64_char(acc[11:6]);
               rec.chars[n + 3'd2] = b64_char(acc[5:0]);
               n = n + 3'd3;
               rem = 4'd0;
               rc = 3'd0;
            end
            3'd4: begin
               rec.chars[n] = b64_char(acc[19:14]);
               rec.chars[n + 3'd1] = b64_char(acc[13:8]);
               rec.chars[n + 3'd2] = b64_char(acc[7:2]);
               n = n + 3'd3;
               rem = {2'b00, acc[1:0]};
               rc = 3'd2;
            end
            default: begin
               rec.chars[n] = b64_char(acc[15:10]);
               rec.chars[n + 3'd1] = b64_char(acc[9:4]);
               n = n + 3'd2;
               rem = acc[3:0];
               rc = 3'd4;
            end
         endcase
         if (req_word.end_of_text) begin
            if (rc != 3'd0) begin
               rec.chars[n] = flush_char(rem, rc);
               n = n + 3'd1;
            end
            rec.chars[n] = CHAR_MINUS;
            n = n + 3'd1;
         end else begin
            run_in   = 1'b1;
            pbits_in = rem;
            pcnt_in  = rc;
         end
      end
      rec.count = n;
   end

   // run state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         pbits_ff <= '0;
         pcnt_ff  <= '0;
      end else if (accept) begin
         run_ff   <= run_in;
         pbits_ff <= pbits_in;
         pcnt_ff  <= pcnt_in;
      end
   end

   a_pcnt_legal: assert property (@(posedge clock) disable iff (reset)
      pcnt_ff == 3'd0 || pcnt_ff == 3'd2 || pcnt_ff == 3'd4)
      else $error("pending count out of range");
   a_direct_no_bits: assert property (@(posedge clock) disable iff (reset)
      !run_ff |-> (pcnt_ff == 3'd0 && pbits_ff == 4'd0))
      else $error("pending bits outside a run");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      accept |-> (rec.count != 3'd0 && rec.count <= 3'd5))
      else $error("bad character count");

endmodule

// ===== sv/u7se_fifo.sv =====
// short record queue between front and back end
// depends on u7se_pkg
module u7se_fifo #(
   parameter int DEPTH = u7se_pkg::U7SE_FIFO_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  u7se_pkg::rec_type       wr_data,
   input  logic                    rd_en,
   output u7se_pkg::rec_type       rd_data,
   output u7se_pkg::fifo_stat_type stat
);
   import u7se_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rec_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_wr, do_rd;

   assign stat.full  = (count_ff == CW'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_wr      = wr_en && !stat.full;
   assign do_rd      = rd_en && !stat.empty;
   assign rd_data    = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count over depth");

endmodule

// ===== sv/u7se_back.sv =====
// back end: walks one record at a time and sends its characters through
// an output register; depends on u7se_pkg
module u7se_back (
   input  logic                    clock,
   input  logic                    reset,
   input  u7se_pkg::rec_type       rec_in,
   input  u7se_pkg::fifo_stat_type stat,
   output logic                    rec_pop,
   output u7se_pkg::rsp_type       out_word,
   output logic                    out_valid,
   input  logic                    out_pop
);
   import u7se_pkg::*;

   rec_type    cur_ff;
   logic       cur_valid_ff, cur_valid_in;
   logic [2:0] idx_ff, idx_in;
   rsp_type    out_ff, out_in;
   logic       out_valid_ff, out_valid_in;

   logic       out_free, send, last_char;

   assign out_free  = !out_valid_ff || out_pop;
   assign send      = cur_valid_ff && out_free;
   assign last_char = (idx_ff == cur_ff.count - 3'd1);
   assign rec_pop   = !stat.empty && (!cur_valid_ff || (send && last_char));
   assign out_word  = out_ff;
   assign out_valid = out_valid_ff;

   // serializer control
   always_comb begin
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = cur_valid_ff;
      end
      if (send) begin
         out_in.ascii_char  = cur_ff.chars[idx_ff];
         out_in.last_of_run = last_char;
         idx_in             = idx_ff + 3'd1;
         if (last_char) begin
            cur_valid_in = 1'b0;
         end
      end
      if (rec_pop) begin
         cur_valid_in = 1'b1;
         idx_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (rec_pop) begin
         cur_ff <= rec_in;
      end
   end

   a_idx_in_record: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (idx_ff < cur_ff.count))
      else $error("character index past record");
   a_record_nonempty: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (cur_ff.count != 3'd0 && cur_ff.count <= 3'd5))
      else $error("record count out of range");
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (send && last_char && stat.empty) |=> !cur_valid_ff)
      else $error("record kept after last character");

endmodule

// ===== sv/utf7_stream_encoder_core.sv =====
// utf-7 stream encoder: one utf-16 code unit in, one to five ascii words out.
// an accepted item passes the record queue and the current-record register before
// its first character shows in the output register, which sends one word per cycle
// while the consumer pops, so characters leave back to back. a two-record
// queue decouples intake, so items are taken back to back until it fills.
// reset (synchronous, active high) empties everything and returns to direct mode.
module utf7_stream_encoder_core #(
   parameter int FIFO_DEPTH = u7se_pkg::U7SE_FIFO_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  u7se_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output u7se_pkg::rsp_type rsp_data
);
   import u7se_pkg::*;

   rec_type       front_rec;
   rec_type       queue_rec;
   fifo_stat_type queue_stat;
   logic          accept;
   logic          rec_pop;
   logic          out_valid;

   assign accept = push && !queue_stat.full;
   assign full   = queue_stat.full;
   assign empty  = !out_valid;

   // classify and build records
   u7se_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_word (req_data),
      .rec      (front_rec)
   );

   // record queue
   u7se_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_data (front_rec),
      .rd_en   (rec_pop),
      .rd_data (queue_rec),
      .stat    (queue_stat)
   );

   // character output
   u7se_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_in    (queue_rec),
      .stat      (queue_stat),
      .rec_pop   (rec_pop),
      .out_word  (rsp_data),
      .out_valid (out_valid),
      .out_pop   (pop)
   );

endmodule
